// File: rtl/snfe_pkg.sv
// shared types, constants and the frame parser step for the nibble frame extractor
package snfe_pkg;

  localparam int unsigned PixW   = 29;
  localparam int unsigned LenW   = 32;
  localparam int unsigned CapW   = 36;
  localparam int unsigned QDepth = 2;

  localparam logic [PixW-1:0] PIXELS_RST = PixW'(65536);
  // header, length and footer bytes in bits
  localparam logic [CapW-1:0] OVERHEAD_BITS = CapW'(80);

  localparam logic [7:0] MARK_F = 8'h46;
  localparam logic [7:0] MARK_C = 8'h43;
  localparam logic [7:0] MARK_D = 8'h44;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_FOOTER  = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    ST_PROGRESS   = 3'd0,
    ST_VALID      = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_BAD_FOOTER = 3'd4
  } status_t;

  // one or two bytes formed from one pixel
  typedef struct packed {
    logic       restart;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } byte_grp_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    phase_t            phase;
    logic [1:0]        idx;
    logic [LenW-1:0]   len;
    status_t           status;
  } parse_t;

  typedef struct packed {
    parse_t s;
    logic   pay;
    logic   done;
  } step_t;

  localparam parse_t PARSE_CLEAR = '{
    phase: PH_HEADER, idx: 2'd0, len: '0, status: ST_PROGRESS
  };

  // expected header or footer byte at a position
  function automatic logic [7:0] mark_byte(input logic foot, input logic [1:0] idx);
    logic [7:0] m;
    m = MARK_C;
    unique case (idx)
      2'd0:    m = foot ? MARK_D : MARK_F;
      2'd1:    m = MARK_C;
      2'd2:    m = foot ? MARK_F : MARK_D;
      default: m = MARK_C;
    endcase
    return m;
  endfunction

  // one byte through the frame parser
  function automatic step_t take_byte(input parse_t s, input logic [7:0] b,
                                      input logic [CapW-1:0] cap);
    step_t           r;
    logic [LenW-1:0] len_n;
    logic [CapW-1:0] need;
    r      = '{s: s, pay: 1'b0, done: 1'b0};
    len_n  = s.len;
    need   = '0;
    unique case (s.phase)
      PH_HEADER, PH_FOOTER: begin
        if (s.idx == 2'd3 || b != mark_byte(s.phase == PH_FOOTER, s.idx)) begin
          r.s.phase  = PH_DONE;
          r.s.status = (s.phase == PH_FOOTER) ? ST_BAD_FOOTER : ST_BAD_HEADER;
          r.done     = 1'b1;
        end else if (s.idx == 2'd2) begin
          r.s.idx = 2'd0;
          if (s.phase == PH_FOOTER) begin
            r.s.phase  = PH_DONE;
            r.s.status = ST_VALID;
            r.done     = 1'b1;
          end else begin
            r.s.phase = PH_LENGTH;
            r.s.len   = '0;
          end
        end else begin
          r.s.idx = s.idx + 2'd1;
        end
      end
      PH_LENGTH: begin
        // little-endian length, lanes start cleared
        len_n[{s.idx, 3'b000} +: 8] = b;
        r.s.len = len_n;
        if (s.idx == 2'd3) begin
          need    = OVERHEAD_BITS + {1'b0, len_n, 3'b000};
          r.s.idx = 2'd0;
          if (need > cap) begin
            r.s.phase  = PH_DONE;
            r.s.status = ST_TOO_LARGE;
            r.done     = 1'b1;
          end else if (len_n == '0) begin
            r.s.phase = PH_FOOTER;
          end else begin
            r.s.phase = PH_PAYLOAD;
          end
        end else begin
          r.s.idx = s.idx + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        // len counts the payload bytes still to come
        r.pay   = 1'b1;
        r.s.len = s.len - LenW'(1);
        if (s.len <= LenW'(1)) begin
          r.s.phase = PH_FOOTER;
          r.s.idx   = 2'd0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// File: rtl/snfe_ifs.sv
// pixel, result and configuration channel interfaces
interface snfe_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       first_pixel;
  modport source(output valid, red, green, blue, first_pixel, input ready);
  modport sink(input valid, red, green, blue, first_pixel, output ready);
endinterface

interface snfe_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_a;
  logic       byte_a_valid;
  logic [7:0] byte_b;
  logic       byte_b_valid;
  logic [2:0] status;
  logic       frame_done;
  modport source(output valid, byte_a, byte_a_valid, byte_b, byte_b_valid, status,
                 frame_done, input ready);
  modport sink(input valid, byte_a, byte_a_valid, byte_b, byte_b_valid, status,
               frame_done, output ready);
endinterface

interface snfe_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [snfe_pkg::PixW-1:0] image_pixels;
  modport source(output valid, image_pixels, input ready);
  modport sink(input valid, image_pixels, output ready);
endinterface

// File: rtl/snfe_front.sv
// front end: accepts pixels and pairs low nibbles into bytes
module snfe_front (
  input  logic                clk,
  input  logic                rst_n,
  snfe_pix_if.sink            in_ch,
  input  snfe_pkg::q_stat_t   q_stat,
  output logic                push,
  output snfe_pkg::byte_grp_t grp
);
  import snfe_pkg::*;

  logic       pending_r, pending_nxt;
  logic [3:0] held_r, held_nxt;
  logic       pend;

  // no word is taken while reset is held
  assign in_ch.ready = rst_n && !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // byte pairing, a restart drops the held nibble
  always_comb begin
    pend        = pending_r && !in_ch.first_pixel;
    grp.restart = in_ch.first_pixel;
    pending_nxt = pending_r;
    held_nxt    = held_r;
    if (pend) begin
      grp.two = 1'b1;
      grp.b0  = {in_ch.red[3:0], held_r};
      grp.b1  = {in_ch.blue[3:0], in_ch.green[3:0]};
    end else begin
      grp.two = 1'b0;
      grp.b0  = {in_ch.green[3:0], in_ch.red[3:0]};
      grp.b1  = '0;
    end
    if (push) begin
      pending_nxt = !pend;
      held_nxt    = pend ? 4'd0 : in_ch.blue[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      held_r    <= 4'd0;
    end else begin
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

// File: rtl/snfe_queue.sv
// short queue of byte groups between front and back
module snfe_queue #(
  parameter int unsigned Depth = snfe_pkg::QDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  snfe_pkg::byte_grp_t push_grp,
  input  logic                pop,
  output snfe_pkg::byte_grp_t pop_grp,
  output snfe_pkg::q_stat_t   q_stat
);
  import snfe_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  byte_grp_t       mem [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CntW'(Depth));
  assign pop_grp      = mem[rd_r];

  // pointer wrap and fill count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + PtrW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_grp;
    end
  end

endmodule

// File: rtl/snfe_back.sv
// back end: frame parser, capacity register and result register
module snfe_back (
  input  logic                clk,
  input  logic                rst_n,
  snfe_cfg_if.sink            cfg_ch,
  input  snfe_pkg::q_stat_t   q_stat,
  input  snfe_pkg::byte_grp_t grp,
  output logic                pop,
  snfe_res_if.source          out_ch
);
  import snfe_pkg::*;

  parse_t          state_r, state_nxt;
  logic [CapW-1:0] cap_r;
  logic            out_valid_r;
  logic [7:0]      byte_a_r, byte_b_r, byte_a_nxt, byte_b_nxt;
  logic            a_valid_r, b_valid_r, a_valid_nxt, b_valid_nxt;
  logic            done_r, done_nxt;
  parse_t          s0;
  step_t           st1, st2;

  // no write is taken while reset is held
  assign cfg_ch.ready = rst_n;
  assign pop          = !q_stat.empty && (!out_valid_r || out_ch.ready);

  // up to two bytes through the parser
  always_comb begin
    s0  = grp.restart ? PARSE_CLEAR : state_r;
    st1 = take_byte(s0, grp.b0, cap_r);
    st2 = '{s: st1.s, pay: 1'b0, done: 1'b0};
    if (grp.two) begin
      st2 = take_byte(st1.s, grp.b1, cap_r);
    end
    state_nxt   = st2.s;
    a_valid_nxt = st1.pay || st2.pay;
    b_valid_nxt = st1.pay && st2.pay;
    byte_a_nxt  = st1.pay ? grp.b0 : (st2.pay ? grp.b1 : 8'd0);
    byte_b_nxt  = b_valid_nxt ? grp.b1 : 8'd0;
    done_nxt    = st1.done || st2.done;
  end

  // parser state, capacity and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PARSE_CLEAR;
      cap_r       <= {4'd0, PIXELS_RST, 3'b000} + {5'd0, PIXELS_RST, 2'b00};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cap_r <= {4'd0, cfg_ch.image_pixels, 3'b000} + {5'd0, cfg_ch.image_pixels, 2'b00};
      end
      if (pop) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_a_r  <= byte_a_nxt;
      a_valid_r <= a_valid_nxt;
      byte_b_r  <= byte_b_nxt;
      b_valid_r <= b_valid_nxt;
      done_r    <= done_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_a       = byte_a_r;
  assign out_ch.byte_a_valid = a_valid_r;
  assign out_ch.byte_b       = byte_b_r;
  assign out_ch.byte_b_valid = b_valid_r;
  assign out_ch.status       = state_r.status;
  assign out_ch.frame_done   = done_r;

endmodule

// File: rtl/stego_nibble_frame_extractor.sv
// top level of the nibble steganography frame extractor
// Takes one pixel per clock while the byte queue is not full and returns one
// result word per pixel. An accepted pixel's byte group goes into the byte
// queue and from there into the result register. The front end only pairs
// nibbles and the back end parses up to two bytes per cycle, so both sides
// keep one word per clock; the queue of QueueDepth groups and the result
// register let each side stall on its own. The capacity limit of 12 bits per
// pixel is precomputed when image_pixels is written, which must happen while
// the block is idle. There is no clearing pass after reset.
module stego_nibble_frame_extractor #(
  parameter int unsigned QueueDepth = snfe_pkg::QDepth
) (
  input logic        clk,
  input logic        rst_n,
  snfe_pix_if.sink   in_ch,
  snfe_res_if.source out_ch,
  snfe_cfg_if.sink   cfg_ch
);
  import snfe_pkg::*;

  q_stat_t   q_stat;
  logic      push, pop;
  byte_grp_t push_grp, pop_grp;

  snfe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .grp    (push_grp)
  );

  snfe_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .pop_grp  (pop_grp),
    .q_stat   (q_stat)
  );

  snfe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .q_stat (q_stat),
    .grp    (pop_grp),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // a verdict word never reads in progress
  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done |-> out_ch.status != ST_PROGRESS)
    else $error("frame_done with status in progress");

  // a second payload byte only follows a first one
  a_b_after_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.byte_b_valid |-> out_ch.byte_a_valid)
    else $error("byte_b valid without byte_a");

  // a valid frame ends on footer bytes, never on payload
  a_valid_no_pay: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_VALID && out_ch.frame_done |-> !out_ch.byte_a_valid)
    else $error("payload byte on the valid frame verdict");

  // the back end only takes from a filled queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule
